### rtl/core/assert_macros.svh
// Assertion helpers shared by the ramp generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define SRP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SRP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/srp_pkg.sv
`timescale 1ns / 1ps
package srp_pkg;

  localparam logic [1:0] REQ_CMD  = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_HALL = 2'd2;

  localparam logic [1:0] CFG_MIN_FREQ = 2'd0;
  localparam logic [1:0] CFG_STEPS    = 2'd1;
  localparam logic [1:0] CFG_MAGNETS  = 2'd2;

  localparam logic [15:0] MIN_FREQ_RST = 16'd400;
  localparam logic [15:0] STEPS_RST    = 16'd2000;
  localparam logic [3:0]  MAGNETS_RST  = 4'd2;

  // one million = 2^US_SHIFT * US_ODD
  localparam int          US_SHIFT  = 6;
  localparam int          US_ODD    = 15625;
  localparam logic [15:0] FREQ_CAP  = 16'hFFFF;
  // accel (16) times elapsed microseconds (20)
  localparam int          AMUS_W    = 36;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;

  typedef struct packed {
    logic       load;
    logic       init;
    logic       mul_step;
    logic       div_step;
    logic       sq_mul;
    logic       sel_fhz;
    logic       brake_cmp;
    logic       bit_cmp;
    logic [3:0] sq_bit;
    logic       update;
    logic       stop_run;
    logic       out_load;
  } srp_cmd_t;

  typedef struct packed {
    logic run;
    logic rem_zero;
    logic mul_done;
    logic out_free;
  } srp_stat_t;

endpackage

### rtl/core/srp_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module srp_ctrl #(
  parameter int FREQ_FRAC_BITS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_req_i,
  output logic              in_ready_o,
  input  srp_pkg::srp_stat_t stat_i,
  output srp_pkg::srp_cmd_t  cmd_o
);
  import srp_pkg::*;

  // one step per 16-bit slice of the reciprocal
  localparam int DIV_STEPS = (AMUS_W + FREQ_FRAC_BITS - US_SHIFT + 16) / 16;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_MUL, S_DIV, S_SQA, S_SQB, S_UPD, S_OUT
  } state_e;

  state_e           state_q;
  logic             ramp_q;
  logic             brk_ph_q;
  logic [3:0]       bit_q;
  logic [CNT_W-1:0] cnt_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o        = '0;
    cmd_o.sq_bit = bit_q;
    unique case (state_q)
      S_IDLE: cmd_o.load = in_valid_i;
      S_EVAL: begin
        if (ramp_q && stat_i.run) begin
          cmd_o.stop_run = stat_i.rem_zero;
          cmd_o.init     = !stat_i.rem_zero;
        end
      end
      S_MUL: cmd_o.mul_step = !stat_i.mul_done;
      S_DIV: cmd_o.div_step = 1'b1;
      S_SQA: begin
        cmd_o.sq_mul  = 1'b1;
        cmd_o.sel_fhz = brk_ph_q;
      end
      S_SQB: begin
        cmd_o.brake_cmp = brk_ph_q;
        cmd_o.bit_cmp   = !brk_ph_q;
      end
      S_UPD: cmd_o.update = 1'b1;
      S_OUT: cmd_o.out_load = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ramp_q   <= 1'b0;
      brk_ph_q <= 1'b0;
      bit_q    <= '0;
      cnt_q    <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            ramp_q  <= (in_req_i == REQ_CMD) || (in_req_i == REQ_TICK);
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          brk_ph_q <= 1'b1;
          bit_q    <= 4'd15;
          cnt_q    <= CNT_W'(DIV_STEPS - 1);
          if (ramp_q && stat_i.run && !stat_i.rem_zero) begin
            state_q <= S_MUL;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_MUL: begin
          if (stat_i.mul_done) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= S_SQA;
          end
        end
        S_SQA: state_q <= S_SQB;
        S_SQB: begin
          if (brk_ph_q) begin
            brk_ph_q <= 1'b0;
            state_q  <= S_SQA;
          end else if (bit_q == '0) begin
            state_q <= S_UPD;
          end else begin
            bit_q   <= bit_q - 1'b1;
            state_q <= S_SQA;
          end
        end
        S_UPD: state_q <= S_OUT;
        S_OUT: begin
          if (stat_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `SRP_ASSERT(a_out_free, clk_i, rst_ni, cmd_o.out_load |-> stat_i.out_free,
              "output overwritten")
  `SRP_ASSERT(a_accept_eval, clk_i, rst_ni,
              (in_valid_i && in_ready_o) |=> (state_q == S_EVAL),
              "accept did not start evaluation")
  `SRP_ASSERT(a_last_bit, clk_i, rst_ni,
              (state_q == S_SQB && !brk_ph_q && bit_q == 4'd0) |=> (state_q == S_UPD),
              "sqrt search did not end")

endmodule

### rtl/core/srp_dp.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module srp_dp #(
  parameter int FREQ_FRAC_BITS = 12,
  parameter int POS_BITS       = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [15:0]                      min_freq_i,
  input  logic [15:0]                      steps_i,
  input  logic [3:0]                       magnets_i,
  input  logic [1:0]                       in_req_i,
  input  logic [srp_pkg::IN_DATA_W-1:0]    in_data_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [srp_pkg::OUT_DATA_W-1:0]   out_data_o,
  input  srp_pkg::srp_cmd_t                cmd_i,
  output srp_pkg::srp_stat_t               stat_o
);
  import srp_pkg::*;

  localparam int F      = FREQ_FRAC_BITS;
  localparam int P      = POS_BITS;
  localparam int FACC_W = 16 + F;
  localparam int DVD_W  = AMUS_W + F;
  localparam int RHS_W  = P + 32;
  localparam int SUM_W  = DVD_W + 1;
  // divide by one million: drop the power of two, then multiply by the
  // rounded-up reciprocal of the odd part, exact for every YW-bit dividend
  localparam int YW     = DVD_W - US_SHIFT;
  localparam int RSH    = YW + $clog2(US_ODD);
  localparam int NCH    = (YW + 16) / 16;
  localparam int MP     = NCH * 16;
  localparam int PW     = 2 * YW + 1;
  localparam int PPW    = YW + 16;
  localparam logic [127:0] RECIP = ((128'd1 << RSH) + 128'(US_ODD - 1)) / 128'(US_ODD);

  // state
  logic              run_q;
  logic [FACC_W-1:0] facc_q;
  logic [P-1:0]      pos_q;
  logic [P-1:0]      goal_q;
  logic              dir_q;
  logic              stop_q;
  logic [15:0]       accel_q;
  logic [15:0]       gfreq_q;
  // working registers
  logic [19:0]       us_q;
  logic [RHS_W-1:0]  mcand_q;
  logic [P-2:0]      rem_sh_q;
  logic [RHS_W-1:0]  rhs_q;
  logic [YW-1:0]     y_q;
  logic [MP-1:0]     rcp_q;
  logic [PW-1:0]     prod_q;
  logic [31:0]       sq_q;
  logic [15:0]       x_q;
  logic              brk_q;
  logic              out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  // input word fields
  logic        f_stop, f_dir;
  logic [7:0]  f_revs;
  logic [15:0] f_accel, f_goal;
  logic [19:0] f_us;
  assign f_stop  = in_data_i[0];
  assign f_dir   = in_data_i[1];
  assign f_revs  = in_data_i[9:2];
  assign f_accel = in_data_i[25:10];
  assign f_goal  = in_data_i[41:26];
  assign f_us    = in_data_i[61:42];

  logic [15:0] fhz;
  logic [P-1:0] diff;
  logic [P-1:0] span;
  logic        rem_zero;
  logic [3:0]  meff;
  logic [15:0] x_try, sq_op;
  logic [35:0] sqm;
  logic [RHS_W-1:0] sqm_ext;
  logic [31:0] ab;
  logic [AMUS_W-1:0] amus;
  logic [PPW-1:0] pp;

  assign fhz      = facc_q[FACC_W-1 -: 16];
  assign diff     = dir_q ? (pos_q - goal_q) : (goal_q - pos_q);
  assign rem_zero = (diff == '0) || diff[P-1];
  assign span     = P'(12'(f_revs) * 12'(magnets_i));
  assign meff     = (magnets_i == '0) ? 4'd1 : magnets_i;
  assign x_try    = x_q | (16'd1 << cmd_i.sq_bit);
  assign sq_op    = cmd_i.sel_fhz ? fhz : x_try;
  assign sqm      = {4'b0, sq_q} * {32'b0, meff};
  assign sqm_ext  = RHS_W'(sqm);
  assign ab       = 32'(accel_q) * 32'(steps_i);
  assign amus     = AMUS_W'(accel_q) * AMUS_W'(us_q);
  assign pp       = PPW'(y_q) * PPW'(rcp_q[MP-1 -: 16]);

  // frequency update toward the selected target
  logic [15:0]       mx, des, tsel;
  logic [SUM_W-1:0]  tgt_w, facc_w, dl_w, n0, n1, n2, floor_w, cap_w;
  logic [FACC_W-1:0] facc_next;

  always_comb begin
    mx      = (x_q < min_freq_i) ? min_freq_i : x_q;
    des     = (gfreq_q < mx) ? gfreq_q : mx;
    tsel    = (stop_q || brk_q) ? min_freq_i : des;
    tgt_w   = SUM_W'({tsel, F'(0)});
    facc_w  = SUM_W'(facc_q);
    dl_w    = SUM_W'(prod_q[PW-1:RSH]);
    floor_w = SUM_W'({min_freq_i, F'(0)});
    cap_w   = SUM_W'({FREQ_CAP, F'(0)});
    if (facc_w < tgt_w) begin
      n0 = facc_w + dl_w;
      n1 = (n0 > tgt_w) ? tgt_w : n0;
    end else begin
      n0 = (facc_w >= dl_w) ? (facc_w - dl_w) : '0;
      n1 = (n0 < tgt_w) ? tgt_w : n0;
    end
    n2 = (n1 < floor_w) ? floor_w : n1;
    if (n2 > cap_w) begin
      n2 = cap_w;
    end
    facc_next = FACC_W'(n2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      facc_q      <= {MIN_FREQ_RST, F'(0)};
      pos_q       <= '0;
      goal_q      <= '0;
      dir_q       <= 1'b0;
      stop_q      <= 1'b1;
      accel_q     <= '0;
      gfreq_q     <= MIN_FREQ_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        case (in_req_i)
          REQ_CMD: begin
            stop_q  <= f_stop;
            dir_q   <= f_dir;
            accel_q <= f_accel;
            gfreq_q <= f_goal;
            goal_q  <= f_dir ? (pos_q - span) : (pos_q + span);
            run_q   <= 1'b1;
          end
          REQ_HALL: pos_q <= dir_q ? (pos_q - 1'b1) : (pos_q + 1'b1);
          default: ;
        endcase
      end
      if (cmd_i.stop_run) begin
        run_q <= 1'b0;
      end
      if (cmd_i.update) begin
        facc_q <= facc_next;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      us_q <= (in_req_i == REQ_TICK) ? f_us : 20'd0;
    end
    if (cmd_i.init) begin
      mcand_q  <= RHS_W'({ab, 1'b0});
      rem_sh_q <= diff[P-2:0];
      rhs_q    <= '0;
      y_q      <= YW'({amus, F'(0)} >> US_SHIFT);
      rcp_q    <= MP'(RECIP);
      prod_q   <= '0;
      x_q      <= '0;
    end
    if (cmd_i.mul_step) begin
      if (rem_sh_q[0]) begin
        rhs_q <= rhs_q + mcand_q;
      end
      mcand_q  <= mcand_q << 1;
      rem_sh_q <= rem_sh_q >> 1;
    end
    // reciprocal product, top 16-bit slice first
    if (cmd_i.div_step) begin
      prod_q <= (prod_q << 16) + PW'(pp);
      rcp_q  <= rcp_q << 16;
    end
    if (cmd_i.sq_mul) begin
      sq_q <= 32'(sq_op) * 32'(sq_op);
    end
    if (cmd_i.brake_cmp) begin
      brk_q <= sqm_ext >= rhs_q;
    end
    if (cmd_i.bit_cmp && (sqm_ext <= rhs_q)) begin
      x_q <= x_try;
    end
    if (cmd_i.out_load) begin
      out_data_q <= {5'b0, 24'(pos_q), run_q, dir_q, fhz, run_q};
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign stat_o.run      = run_q;
  assign stat_o.rem_zero = rem_zero;
  assign stat_o.mul_done = (rem_sh_q == '0);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  `SRP_ASSERT(a_run_fall, clk_i, rst_ni, $fell(run_q) |-> $past(cmd_i.stop_run),
              "run cleared without stop")
  `SRP_ASSERT(a_freq_range, clk_i, rst_ni,
              cmd_i.update |=> (facc_q <= FACC_W'({FREQ_CAP, F'(0)}) &&
                                facc_q >= FACC_W'({min_freq_i, F'(0)})),
              "frequency out of range")
  `SRP_ASSERT(a_pos_hold, clk_i, rst_ni, !cmd_i.load |=> $stable(pos_q),
              "position moved without a word")
  `SRP_ASSERT_ALWAYS(a_rst_out, clk_i, !rst_ni |=> !out_valid_q, "output valid in reset")

endmodule

### rtl/core/stepper_ramp_profile.sv
`timescale 1ns / 1ps
// Hall pulses and words that need no ramp go from evaluation straight to the output state.
// Command and tick words that start a ramp first pass the shift-add multiplier over the
// remaining-distance bits, a reciprocal divide in 16-bit slices and the sqrt search.
// The block takes one word at a time; a finished result waits in the output register.
// Reset: asynchronous, active low; config and ramp state return to defaults, no clearing pass.
module stepper_ramp_profile #(
  parameter int FREQ_FRAC_BITS = 12,
  parameter int POS_BITS       = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // stop_mode, move_dir, num_revs[7:0], accel[15:0], goal_freq[15:0], elapsed_us[19:0]
  input  logic [63:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // step_enable, step_freq[15:0], dir_level, ramping, position_pulses[23:0]
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import srp_pkg::*;

  logic [15:0] min_freq_q;
  logic [15:0] steps_q;
  logic [3:0]  magnets_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_freq_q <= MIN_FREQ_RST;
      steps_q    <= STEPS_RST;
      magnets_q  <= MAGNETS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MIN_FREQ: min_freq_q <= cfg_data_i;
        CFG_STEPS:    steps_q    <= cfg_data_i;
        CFG_MAGNETS:  magnets_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  srp_cmd_t  cmd;
  srp_stat_t stat;

  srp_ctrl #(
    .FREQ_FRAC_BITS(FREQ_FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_req_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  srp_dp #(
    .FREQ_FRAC_BITS(FREQ_FRAC_BITS),
    .POS_BITS      (POS_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .min_freq_i  (min_freq_q),
    .steps_i     (steps_q),
    .magnets_i   (magnets_q),
    .in_req_i    (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
